@@ rtl/core/lca_binary_lifting_engine_top_assert.svh @@
// Assertion macros for the binary lifting engine.
`ifndef LCA_BINARY_LIFTING_ENGINE_TOP_ASSERT_SVH
`define LCA_BINARY_LIFTING_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LCAB_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lca engine assertion failed");
`define LCAB_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lca engine assertion failed");
`else
`define LCAB_ASSERT_IMP(name, ante, cons)
`define LCAB_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ rtl/core/lcab_pkg.sv @@
package lcab_pkg;

    localparam int ID_W      = 10;
    localparam int DEPTH_W   = 10;
    localparam int LVL_MAX_W = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic                 lift;
        logic [ID_W-1:0]      u;
        logic [ID_W-1:0]      v;
        logic [ID_W-1:0]      jump_u;
        logic [ID_W-1:0]      jump_v;
        logic [DEPTH_W-1:0]   depth_u;
        logic [DEPTH_W-1:0]   depth_v;
        logic [LVL_MAX_W-1:0] level;
    } step_in_t;

    typedef struct packed {
        logic [ID_W-1:0] u;
        logic [ID_W-1:0] v;
    } step_out_t;

endpackage

@@ rtl/core/lca_binary_lifting_engine_top.sv @@
// Insert: S_INS writes the parent entry, S_INS_LP fills the remaining jump levels, then
// S_OUT returns an acknowledge (an insert of node 0 or of an out-of-range node goes
// straight to S_OUT). Query: the deeper node is lifted (S_QLIFT), then both climb
// together (S_QCMN, S_QFIN); equal nodes, or a lift that meets the other node, end early.
// The next beat is taken when the result appears; memory reads are registered, and a stalled result holds input.
// Reset (aresetn, synchronous) clears control only; node 0 reads as zero by decode.
module lca_binary_lifting_engine_top import lcab_pkg::*; #(
    parameter int NODE_COUNT  = 1024,
    parameter int JUMP_LEVELS = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_req_type,
    input  logic [ID_W-1:0] s_node_a,
    input  logic [ID_W-1:0] s_node_b,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [ID_W-1:0] m_ancestor_node,
    output logic            m_is_answer
);

`include "lca_binary_lifting_engine_top_assert.svh"

    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int JADDR_W = $clog2(NODE_COUNT * JUMP_LEVELS);
    localparam int LVL_W   = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(JUMP_LEVELS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_INS_LP, S_QDEP, S_QSW, S_QLIFT, S_QCMN, S_QFIN, S_OUT
    } state_t;

    function automatic logic in_range(input logic [ID_W-1:0] id);
        return 32'(id) < 32'(NODE_COUNT);
    endfunction

    function automatic logic [ID_W-1:0] clamp_id(input logic [ID_W-1:0] id);
        return in_range(id) ? id : '0;
    endfunction

    function automatic logic [ADDR_W-1:0] node_addr(input logic [ID_W-1:0] id);
        return ADDR_W'(id);
    endfunction

    function automatic logic [JADDR_W-1:0] jump_addr(input logic [ID_W-1:0] id,
                                                    input logic [LVL_W-1:0] lvl);
        return JADDR_W'(id) * JADDR_W'(JUMP_LEVELS) + JADDR_W'(lvl);
    endfunction

    logic [DEPTH_W-1:0] depth_mem [NODE_COUNT];
    logic [ID_W-1:0]    jump_mem  [NODE_COUNT * JUMP_LEVELS];

    state_t             state_reg, state_next;
    logic [ID_W-1:0]    u_reg, u_next;
    logic [ID_W-1:0]    v_reg, v_next;
    logic [DEPTH_W-1:0] dv_reg, dv_next;
    logic [LVL_W-1:0]   k_reg, k_next;
    logic [ID_W-1:0]    res_node_reg, res_node_next;
    logic               res_ans_reg, res_ans_next;
    logic               m_valid_reg, m_valid_next;
    logic [ID_W-1:0]    m_node_reg, m_node_next;
    logic               m_ans_reg, m_ans_next;

    // memory port controls
    logic               dep_re_a, dep_re_b, dep_we, jmp_re_a, jmp_re_b, jmp_we;
    logic [ID_W-1:0]    dep_ra_a, dep_ra_b, jmp_ra_a, jmp_ra_b, wr_id, jmp_wd;
    logic [LVL_W-1:0]   jmp_rl_a, jmp_rl_b, jmp_wl;
    logic [DEPTH_W-1:0] dep_wd;

    logic [DEPTH_W-1:0] dep_rd_a_reg, dep_rd_b_reg;
    logic               dep_z_a_reg, dep_z_b_reg;
    logic [ID_W-1:0]    jmp_rd_a_reg, jmp_rd_b_reg, jmp_fwd_data_reg;
    logic               jmp_z_a_reg, jmp_z_b_reg, jmp_fwd_reg;

    logic [DEPTH_W-1:0] dep_a, dep_b;
    logic [ID_W-1:0]    jmp_a, jmp_b;
    logic [ID_W-1:0]    in_a, in_b, deep_id;
    logic               swap;

    step_in_t           step_in;
    step_out_t          step_out;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_ancestor_node = m_node_reg;
    assign m_is_answer     = m_ans_reg;

    assign wr_id = u_reg;

    // Node 0 is never written, so its depth and row read as zero.
    assign dep_a = dep_z_a_reg ? '0 : dep_rd_a_reg;
    assign dep_b = dep_z_b_reg ? '0 : dep_rd_b_reg;
    assign jmp_a = jmp_fwd_reg ? jmp_fwd_data_reg : (jmp_z_a_reg ? '0 : jmp_rd_a_reg);
    assign jmp_b = jmp_z_b_reg ? '0 : jmp_rd_b_reg;

    assign in_a    = clamp_id(s_node_a);
    assign in_b    = clamp_id(s_node_b);
    assign swap    = (dep_a < dep_b);
    assign deep_id = swap ? v_reg : u_reg;

    assign step_in.lift    = (state_reg == S_QLIFT);
    assign step_in.u       = u_reg;
    assign step_in.v       = v_reg;
    assign step_in.jump_u  = jmp_a;
    assign step_in.jump_v  = jmp_b;
    assign step_in.depth_u = dep_a;
    assign step_in.depth_v = dv_reg;
    assign step_in.level   = LVL_MAX_W'(k_reg);

    lcab_step u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    always_ff @(posedge aclk) begin
        if (dep_we) begin
            depth_mem[node_addr(wr_id)] <= dep_wd;
        end
        if (dep_re_a) begin
            dep_rd_a_reg <= depth_mem[node_addr(dep_ra_a)];
            dep_z_a_reg  <= (dep_ra_a == '0);
        end
        if (dep_re_b) begin
            dep_rd_b_reg <= depth_mem[node_addr(dep_ra_b)];
            dep_z_b_reg  <= (dep_ra_b == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (jmp_we) begin
            jump_mem[jump_addr(wr_id, jmp_wl)] <= jmp_wd;
        end
        if (jmp_re_a) begin
            jmp_rd_a_reg     <= jump_mem[jump_addr(jmp_ra_a, jmp_rl_a)];
            jmp_z_a_reg      <= (jmp_ra_a == '0);
            // A read of the entry written in the same cycle takes the new value.
            jmp_fwd_reg      <= jmp_we &&
                                (jump_addr(wr_id, jmp_wl) == jump_addr(jmp_ra_a, jmp_rl_a));
            jmp_fwd_data_reg <= jmp_wd;
        end
        if (jmp_re_b) begin
            jmp_rd_b_reg <= jump_mem[jump_addr(jmp_ra_b, jmp_rl_b)];
            jmp_z_b_reg  <= (jmp_ra_b == '0);
        end
    end

    always_comb begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        dv_next       = dv_reg;
        k_next        = k_reg;
        res_node_next = res_node_reg;
        res_ans_next  = res_ans_reg;
        m_valid_next  = m_valid_reg;
        m_node_next   = m_node_reg;
        m_ans_next    = m_ans_reg;
        dep_re_a      = 1'b0;
        dep_re_b      = 1'b0;
        dep_we        = 1'b0;
        dep_ra_a      = u_reg;
        dep_ra_b      = v_reg;
        dep_wd        = (dep_a == DEPTH_MAX) ? DEPTH_MAX : dep_a + 1'b1;
        jmp_re_a      = 1'b0;
        jmp_re_b      = 1'b0;
        jmp_we        = 1'b0;
        jmp_ra_a      = u_reg;
        jmp_ra_b      = v_reg;
        jmp_rl_a      = k_reg;
        jmp_rl_b      = k_reg;
        jmp_wl        = k_reg;
        jmp_wd        = jmp_a;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_req_type)
                        REQ_INSERT: begin
                            if (in_range(s_node_a) && (s_node_a != '0)) begin
                                u_next     = s_node_a;
                                v_next     = in_b;
                                state_next = S_INS;
                            end else begin
                                res_node_next = '0;
                                res_ans_next  = 1'b0;
                                state_next    = S_OUT;
                            end
                        end
                        REQ_QUERY: begin
                            if (in_a == in_b) begin
                                res_node_next = in_a;
                                res_ans_next  = 1'b1;
                                state_next    = S_OUT;
                            end else begin
                                u_next     = in_a;
                                v_next     = in_b;
                                state_next = S_QDEP;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                // The parent is jump entry 0; its own entry 0 gives entry 1.
                dep_re_a   = 1'b1;
                dep_ra_a   = v_reg;
                jmp_we     = 1'b1;
                jmp_wl     = '0;
                jmp_wd     = v_reg;
                jmp_re_a   = 1'b1;
                jmp_ra_a   = v_reg;
                jmp_rl_a   = '0;
                k_next     = LVL_W'(1);
                state_next = S_INS_LP;
            end
            S_INS_LP: begin
                dep_we = 1'b1;
                if (JUMP_LEVELS == 1) begin
                    res_node_next = '0;
                    res_ans_next  = 1'b0;
                    state_next    = S_OUT;
                end else begin
                    jmp_we = 1'b1;
                    if (k_reg == LAST_LVL) begin
                        res_node_next = '0;
                        res_ans_next  = 1'b0;
                        state_next    = S_OUT;
                    end else begin
                        jmp_re_a = 1'b1;
                        jmp_ra_a = jmp_a;
                        k_next   = k_reg + 1'b1;
                    end
                end
            end
            S_QDEP: begin
                dep_re_a   = 1'b1;
                dep_re_b   = 1'b1;
                state_next = S_QSW;
            end
            S_QSW: begin
                if (swap) begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    dv_next = dep_a;
                end else begin
                    dv_next = dep_b;
                end
                dep_re_a   = 1'b1;
                dep_ra_a   = deep_id;
                jmp_re_a   = 1'b1;
                jmp_ra_a   = deep_id;
                jmp_rl_a   = LAST_LVL;
                k_next     = LAST_LVL;
                state_next = S_QLIFT;
            end
            S_QLIFT: begin
                u_next = step_out.u;
                if (k_reg == '0) begin
                    if (step_out.u == v_reg) begin
                        res_node_next = step_out.u;
                        res_ans_next  = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        jmp_re_a   = 1'b1;
                        jmp_ra_a   = step_out.u;
                        jmp_rl_a   = LAST_LVL;
                        jmp_re_b   = 1'b1;
                        jmp_rl_b   = LAST_LVL;
                        k_next     = LAST_LVL;
                        state_next = S_QCMN;
                    end
                end else begin
                    dep_re_a = 1'b1;
                    dep_ra_a = step_out.u;
                    jmp_re_a = 1'b1;
                    jmp_ra_a = step_out.u;
                    jmp_rl_a = k_reg - 1'b1;
                    k_next   = k_reg - 1'b1;
                end
            end
            S_QCMN: begin
                u_next   = step_out.u;
                v_next   = step_out.v;
                jmp_re_a = 1'b1;
                jmp_ra_a = step_out.u;
                if (k_reg == '0) begin
                    jmp_rl_a   = '0;
                    state_next = S_QFIN;
                end else begin
                    jmp_rl_a = k_reg - 1'b1;
                    jmp_re_b = 1'b1;
                    jmp_ra_b = step_out.v;
                    jmp_rl_b = k_reg - 1'b1;
                    k_next   = k_reg - 1'b1;
                end
            end
            S_QFIN: begin
                res_node_next = jmp_a;
                res_ans_next  = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_node_next  = res_node_reg;
                    m_ans_next   = res_ans_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        u_reg        <= u_next;
        v_reg        <= v_next;
        dv_reg       <= dv_next;
        k_reg        <= k_next;
        res_node_reg <= res_node_next;
        res_ans_reg  <= res_ans_next;
        m_node_reg   <= m_node_next;
        m_ans_reg    <= m_ans_next;
    end

    `LCAB_ASSERT_NXT(a_busy_after_beat, s_valid && s_ready, !s_ready)
    `LCAB_ASSERT_IMP(a_ack_is_zero, m_valid && !m_is_answer, m_ancestor_node == '0)
    `LCAB_ASSERT_IMP(a_root_row_kept, jmp_we || dep_we, wr_id != '0)

endmodule

@@ rtl/core/lcab_step.sv @@
module lcab_step import lcab_pkg::*; (
    input  step_in_t  step_in,
    output step_out_t step_out
);

    logic [DEPTH_W-1:0] depth_gap;
    logic               lift_ok;
    logic               split;

    // A lift by 2^level is taken while the depth gap is at least 2^level.
    assign depth_gap = step_in.depth_u - step_in.depth_v;
    assign lift_ok   = (step_in.depth_u >= step_in.depth_v) &&
                       ((depth_gap >> step_in.level) != '0);
    assign split     = (step_in.jump_u != step_in.jump_v);

    always_comb begin
        step_out.u = step_in.u;
        step_out.v = step_in.v;
        if (step_in.lift) begin
            if (lift_ok) begin
                step_out.u = step_in.jump_u;
            end
        end else if (split) begin
            step_out.u = step_in.jump_u;
            step_out.v = step_in.jump_v;
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import lcab_pkg::*;

    localparam int NODES      = 1024;
    localparam int LEVELS     = 10;
    localparam int WATCH_MAX  = 4000;
    localparam int SAT_INSERTS = 1030;

    typedef struct {
        logic [ID_W-1:0] ancestor;
        logic            is_answer;
    } lca_result_t;

    // Keeps its own copy of the depth store and the jump table and predicts
    // the result of every accepted request beat.
    class lca_scoreboard;
        logic [DEPTH_W-1:0] tree_depth [NODES];
        logic [ID_W-1:0]    tree_jump [NODES*LEVELS];
        lca_result_t        pending_results [$];
        int                 mismatches;

        function new();
            foreach (tree_depth[i]) tree_depth[i] = '0;
            foreach (tree_jump[i]) tree_jump[i] = '0;
            mismatches = 0;
        endfunction

        function void grow_tree(int node, int parent);
            int d;
            int mid;
            if (node == 0) return;
            d = int'(tree_depth[parent]) + 1;
            if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
            tree_depth[node] = d[DEPTH_W-1:0];
            tree_jump[node*LEVELS] = parent[ID_W-1:0];
            for (int k = 1; k < LEVELS; k++) begin
                mid = int'(tree_jump[node*LEVELS + k - 1]);
                tree_jump[node*LEVELS + k] = tree_jump[mid*LEVELS + k - 1];
            end
        endfunction

        function int common_ancestor(int u, int v);
            int t;
            int du;
            int dv;
            if (u == v) return u;
            if (tree_depth[u] < tree_depth[v]) begin
                t = u;
                u = v;
                v = t;
            end
            for (int k = LEVELS - 1; k >= 0; k--) begin
                du = int'(tree_depth[u]);
                dv = int'(tree_depth[v]);
                if (du >= dv && du - dv >= (1 << k)) u = int'(tree_jump[u*LEVELS + k]);
            end
            if (u == v) return u;
            for (int k = LEVELS - 1; k >= 0; k--) begin
                if (tree_jump[u*LEVELS + k] != tree_jump[v*LEVELS + k]) begin
                    u = int'(tree_jump[u*LEVELS + k]);
                    v = int'(tree_jump[v*LEVELS + k]);
                end
            end
            return int'(tree_jump[u*LEVELS]);
        endfunction

        function void note_request(logic req, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            lca_result_t r;
            int anc;
            if (req == REQ_INSERT) begin
                grow_tree(int'(a), int'(b));
                r.ancestor  = '0;
                r.is_answer = 1'b0;
            end else begin
                anc = common_ancestor(int'(a), int'(b));
                r.ancestor  = anc[ID_W-1:0];
                r.is_answer = 1'b1;
            end
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_response(logic [ID_W-1:0] anc, logic ans);
            lca_result_t r;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with no request pending: ancestor %0d answer %0b",
                             anc, ans);
                return;
            end
            r = pending_results.pop_front();
            if (anc !== r.ancestor || ans !== r.is_answer) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0b, got %0d/%0b (ancestor/answer)",
                             r.ancestor, r.is_answer, anc, ans);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic            aclk;
    logic            aresetn      = 1'b0;
    logic            s_valid      = 1'b0;
    logic            s_ready;
    logic            s_req_type   = REQ_INSERT;
    logic [ID_W-1:0] s_node_a     = '0;
    logic [ID_W-1:0] s_node_b     = '0;
    logic            m_valid;
    logic            m_ready      = 1'b0;
    logic [ID_W-1:0] m_ancestor_node;
    logic            m_is_answer;

    lca_scoreboard sb;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  rx_hold_req  = 0;
    int  rx_hold_left = 0;
    int  quiet_cycles = 0;

    // Nodes already inserted by the stimulus; only these and the root node 0 are ever read.
    bit  node_known [NODES];
    int  known_ids [$];
    int  free_ids [$];

    lca_binary_lifting_engine_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_node_a        (s_node_a),
        .s_node_b        (s_node_b),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ancestor_node (m_ancestor_node),
        .m_is_answer     (m_is_answer)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_response(m_ancestor_node, m_is_answer);
            if (s_valid && s_ready) sb.note_request(s_req_type, s_node_a, s_node_b);
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCH_MAX) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic offer_request(logic req, int a, int b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_node_a   <= a[ID_W-1:0];
        s_node_b   <= b[ID_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic add_node(int n, int p);
        if (n != 0 && !node_known[n]) begin
            node_known[n] = 1'b1;
            known_ids.insert(known_ids.size(), n);
            for (int i = 0; i < free_ids.size(); i++) begin
                if (free_ids[i] == n) begin
                    free_ids.delete(i);
                    break;
                end
            end
        end
        offer_request(REQ_INSERT, n, p);
    endtask

    task automatic ask_lca(int a, int b);
        offer_request(REQ_QUERY, a, b);
    endtask

    // Often picks one of the eight newest nodes so that chains grow deep; sometimes the root.
    function automatic int pick_known();
        int sz;
        int span;
        sz = known_ids.size();
        if (sz == 0 || $urandom_range(99) < 4) return 0;
        if ($urandom_range(1) == 1) begin
            span = (sz - 1 < 7) ? sz - 1 : 7;
            return known_ids[sz - 1 - $urandom_range(span)];
        end
        return known_ids[$urandom_range(sz - 1)];
    endfunction

    task automatic random_request();
        int r;
        int n;
        int p;
        int idx;
        r = $urandom_range(99);
        if (r < 45 || known_ids.size() == 0) begin
            r = $urandom_range(99);
            if (r < 5) begin
                // Insert of the sentinel is acknowledged and otherwise ignored.
                offer_request(REQ_INSERT, 0, pick_known());
            end else if (free_ids.size() > 0 && (r < 75 || known_ids.size() == 0)) begin
                p   = pick_known();
                idx = $urandom_range(free_ids.size() - 1);
                n   = free_ids[idx];
                add_node(n, p);
            end else begin
                // Re-insert, possibly under its own descendant, which forms a cycle.
                add_node(known_ids[$urandom_range(known_ids.size() - 1)], pick_known());
            end
        end else begin
            n = pick_known();
            p = ($urandom_range(99) < 10) ? n : pick_known();
            ask_lca(n, p);
        end
    endtask

    task automatic run_phase(int count, int idle, int stall);
        tx_idle_pct  = idle;
        rx_stall_pct = stall;
        repeat (count) random_request();
    endtask

    initial begin
        int sat_node;
        sb = new();
        for (int i = 1; i < NODES; i++) free_ids.insert(free_ids.size(), i);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        ask_lca(0, 0);
        add_node(1, 0);
        add_node(2, 1);
        add_node(3, 1);
        add_node(1023, 2);
        ask_lca(1023, 3);
        ask_lca(3, 1023);
        ask_lca(1023, 1023);
        ask_lca(2, 1023);
        ask_lca(1023, 0);
        ask_lca(0, 1);
        add_node(0, 1023);
        add_node(682, 1023);
        add_node(341, 682);
        add_node(512, 341);
        ask_lca(512, 3);
        ask_lca(341, 1023);
        add_node(3, 1023);
        ask_lca(3, 2);
        ask_lca(512, 3);
        add_node(2, 3);
        ask_lca(1023, 1);
        ask_lca(512, 2);

        run_phase(230, 0, 0);

        // A node inserted under itself gains one level each time, which
        // drives its depth into saturation.
        sat_node = free_ids[$urandom_range(free_ids.size() - 1)];
        add_node(sat_node, pick_known());
        repeat (SAT_INSERTS) begin
            add_node(sat_node, sat_node);
            if ($urandom_range(31) == 0) ask_lca(sat_node, pick_known());
        end
        add_node(free_ids[$urandom_range(free_ids.size() - 1)], sat_node);
        ask_lca(known_ids[known_ids.size() - 1], 1023);

        run_phase(230, 54, 0);
        rx_hold_req = 400;
        run_phase(230, 0, 54);
        run_phase(230, 32, 32);

        s_valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lcab_pkg.sv
rtl/core/lcab_step.sv
rtl/core/lca_binary_lifting_engine_top.sv
dv/tb_top.sv
